// ----- hw/rtl/cbmt_pkg.sv -----
package cbmt_pkg;

  // Default sizes of the bank.
  localparam int NumCountersDef = 64;
  localparam int CountBitsDef   = 16;

  // Fixed field widths of the ports.
  localparam int CfgWidth     = 7;
  localparam int ReqWidth     = 2;
  localparam int IndexWidth   = 6;
  localparam int ValueWidth   = 16;
  localparam int HoldersWidth = 7;

  // Counters in use after reset.
  localparam logic [CfgWidth-1:0] CfgResetValue = 7'd64;

  typedef enum logic [ReqWidth-1:0] {
    REQ_INC   = 2'd0,
    REQ_DEC   = 2'd1,
    REQ_CLR   = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_e;

endpackage

// ----- hw/rtl/cbmt_ram.sv -----
module cbmt_ram
  import cbmt_pkg::*;
#(
  parameter int WIDTH = CountBitsDef,
  parameter int DEPTH = NumCountersDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/counter_bank_max_tracker_unit.sv -----
// Bank of saturating signed counters held in one RAM, with the largest value among the
// counters in use and the number of its holders kept alongside. A request word is taken
// when start_i is high, busy_o is low and cfg_we_i is low; it passes through the accept
// cycle and the RAM read cycle, where the counter is modified and written back, and its
// result is then registered onto done_o for exactly one cycle. When a request moves the
// only counter at the maximum below it, the block sweeps the counters in use through the
// RAM read port, one per cycle, before the result word. A write of counters_in_use while
// idle or during a sweep starts the same sweep, with busy_o high until it ends and no
// result. After reset a clearing pass writes zero to all NUM_COUNTERS entries, one per
// cycle, with busy_o high throughout.
module counter_bank_max_tracker_unit
  import cbmt_pkg::*;
#(
  parameter int NUM_COUNTERS = NumCountersDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CfgWidth-1:0]            cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [ReqWidth-1:0]            req_type_i,
  input  logic [IndexWidth-1:0]          counter_index_i,
  output logic                           done_o,
  output logic signed [ValueWidth-1:0]   counter_value_o,
  output logic signed [ValueWidth-1:0]   max_value_o,
  output logic [HoldersWidth-1:0]        max_holders_o,
  output logic                           bad_index_o
);

  localparam int AW   = $clog2(NUM_COUNTERS);
  localparam int NW   = $clog2(NUM_COUNTERS + 1);
  localparam int CMPW = (NW > CfgWidth) ? NW : CfgWidth;
  localparam int IXW  = (NW > IndexWidth) ? NW : IndexWidth;
  localparam logic [AW-1:0] LastAddr = AW'(NUM_COUNTERS - 1);
  localparam logic signed [COUNT_BITS-1:0] CntMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CntMin = {1'b1, {(COUNT_BITS-1){1'b0}}};

  function automatic logic [NW-1:0] active_count(input logic [CfgWidth-1:0] r);
    logic [CMPW-1:0] rr;
    rr = CMPW'(r);
    if (r == '0) begin
      return NW'(1);
    end
    if (rr > CMPW'(NUM_COUNTERS)) begin
      return NW'(NUM_COUNTERS);
    end
    return NW'(r);
  endfunction

  function automatic logic [ValueWidth-1:0] to_value(input logic signed [COUNT_BITS-1:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[ValueWidth-1:0];
  endfunction

  state_e                  state_q, state_d;
  logic [CfgWidth-1:0]     cfg_q;
  logic [AW-1:0]           clr_q, clr_d;
  logic [NW-1:0]           scan_q, scan_d;
  logic                    dv_q, dv_d;
  logic                    first_q, first_d;
  logic                    last_q, last_d;
  logic                    emit_q, emit_d;
  logic                    done_q, done_d;
  logic signed [COUNT_BITS-1:0] best_q, best_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic signed [COUNT_BITS-1:0] max_q, max_d;
  logic [NW-1:0]           hold_q, hold_d;
  logic signed [COUNT_BITS-1:0] val_q, val_d;
  logic                    bad_q, bad_d;
  req_e                    req_q, req_d;
  logic [AW-1:0]           idx_q, idx_d;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [COUNT_BITS-1:0]   ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [COUNT_BITS-1:0]   ram_rdata;

  logic [NW-1:0]           n_act;
  logic signed [COUNT_BITS-1:0] rd_val;
  logic signed [COUNT_BITS-1:0] new_val;
  logic signed [COUNT_BITS-1:0] acc_best;
  logic [NW-1:0]           acc_cnt;
  logic                    accept;

  cbmt_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_COUNTERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign n_act  = active_count(cfg_q);
  assign rd_val = ram_rdata;
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Saturating update of the counter that was just read.
  always_comb begin
    new_val = rd_val;
    case (req_q)
      REQ_INC: if (rd_val != CntMax) new_val = rd_val + COUNT_BITS'(1);
      REQ_DEC: if (rd_val != CntMin) new_val = rd_val - COUNT_BITS'(1);
      REQ_CLR: new_val = '0;
      default: new_val = rd_val;
    endcase
  end

  // Running maximum and holder count of the sweep.
  always_comb begin
    acc_best = best_q;
    acc_cnt  = cnt_q;
    if (first_q || (rd_val > best_q)) begin
      acc_best = rd_val;
      acc_cnt  = NW'(1);
    end else if (rd_val == best_q) begin
      acc_cnt = cnt_q + NW'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    scan_d    = scan_q;
    dv_d      = 1'b0;
    first_d   = 1'b0;
    last_d    = 1'b0;
    emit_d    = emit_q;
    done_d    = 1'b0;
    best_d    = best_q;
    cnt_d     = cnt_q;
    max_d     = max_q;
    hold_d    = hold_q;
    val_d     = val_q;
    bad_d     = bad_q;
    req_d     = req_q;
    idx_d     = idx_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_val;
    ram_raddr = AW'(counter_index_i);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
          max_d   = '0;
          hold_d  = n_act;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (cfg_we_i) begin
          state_d = ST_SCAN;
          scan_d  = '0;
          emit_d  = 1'b0;
        end else if (start_i) begin
          req_d   = req_e'(req_type_i);
          idx_d   = AW'(counter_index_i);
          bad_d   = (IXW'(counter_index_i) >= IXW'(n_act));
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        if (bad_q) begin
          val_d  = '0;
          done_d = 1'b1;
        end else begin
          ram_we = 1'b1;
          val_d  = new_val;
          done_d = 1'b1;
          if (new_val != rd_val) begin
            if (new_val > max_q) begin
              max_d  = new_val;
              hold_d = NW'(1);
            end else if (new_val == max_q) begin
              hold_d = hold_q + NW'(1);
            end else if (rd_val == max_q) begin
              // The counter left the maximum; if it was the only holder, sweep again.
              if (hold_q == NW'(1)) begin
                state_d = ST_SCAN;
                scan_d  = '0;
                emit_d  = 1'b1;
                done_d  = 1'b0;
              end else begin
                hold_d = hold_q - NW'(1);
              end
            end
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = scan_q[AW-1:0];
        if (scan_q < n_act) begin
          dv_d    = 1'b1;
          first_d = (scan_q == '0);
          last_d  = (scan_q == (n_act - NW'(1)));
          scan_d  = scan_q + NW'(1);
        end
        if (dv_q) begin
          best_d = acc_best;
          cnt_d  = acc_cnt;
          if (last_q) begin
            max_d   = acc_best;
            hold_d  = acc_cnt;
            state_d = ST_IDLE;
            done_d  = emit_q;
            emit_d  = 1'b0;
          end
        end
        if (cfg_we_i) begin
          state_d = ST_SCAN;
          scan_d  = '0;
          dv_d    = 1'b0;
          done_d  = 1'b0;
          emit_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cfg_q   <= CfgResetValue;
      clr_q   <= '0;
      scan_q  <= '0;
      dv_q    <= 1'b0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
      emit_q  <= 1'b0;
      done_q  <= 1'b0;
      max_q   <= '0;
      hold_q  <= active_count(CfgResetValue);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      dv_q    <= dv_d;
      first_q <= first_d;
      last_q  <= last_d;
      emit_q  <= emit_d;
      done_q  <= done_d;
      max_q   <= max_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    cnt_q  <= cnt_d;
    val_q  <= val_d;
    bad_q  <= bad_d;
    req_q  <= req_d;
    idx_q  <= idx_d;
  end

  logic [31:0] hold_wide;
  assign hold_wide = 32'(hold_q);

  assign done_o          = done_q;
  assign counter_value_o = to_value(val_q);
  assign max_value_o     = to_value(max_q);
  assign max_holders_o   = hold_wide[HoldersWidth-1:0];
  assign bad_index_o     = bad_q;

  // A result word only follows the read cycle or the end of a sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_READ || $past(state_q) == ST_SCAN))
    else $error("result word without a finished request");

  // An accepted word is always modified in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> (state_q == ST_READ))
    else $error("accepted word did not reach the read cycle");

  // At least one counter in use always holds the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q != '0)
    else $error("holder count dropped to zero");

  // An ignored request reports a zero counter value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_index_o) |-> (counter_value_o == '0))
    else $error("bad index with nonzero counter value");

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbmt_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 2 * NumCountersDef + 8;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned WordsPerPhase = 104;
  localparam logic signed [ValueWidth-1:0] CountTop    = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam logic signed [ValueWidth-1:0] CountBottom = {1'b1, {(ValueWidth-1){1'b0}}};

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic signed [ValueWidth-1:0] peak;
    logic [HoldersWidth-1:0]      holders;
    logic                         bad;
  } tally_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CfgWidth-1:0]   count;
    req_e                  req;
    logic [IndexWidth-1:0] index;
    logic                  typed;
    tally_t                want;
  } plan_row_t;

  // Rows with typed set carry the result written out by hand; the others are predicted.
  localparam int NumRows = 25;
  localparam plan_row_t Plan [NumRows] = '{
    '{1'b0, 7'd0,   REQ_QUERY, 6'd0,  1'b1, '{16'sd0,  16'sd0,  7'd64, 1'b0}},
    '{1'b0, 7'd0,   REQ_INC,   6'd63, 1'b1, '{16'sd1,  16'sd1,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_INC,   6'd63, 1'b1, '{16'sd2,  16'sd2,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_DEC,   6'd0,  1'b1, '{-16'sd1, 16'sd2,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_DEC,   6'd63, 1'b1, '{16'sd1,  16'sd1,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_CLR,   6'd63, 1'b1, '{16'sd0,  16'sd0,  7'd63, 1'b0}},
    '{1'b1, 7'd3,   REQ_INC,   6'd0,  1'b0, '0},
    '{1'b0, 7'd0,   REQ_QUERY, 6'd5,  1'b1, '{16'sd0,  16'sd0,  7'd2,  1'b1}},
    '{1'b0, 7'd0,   REQ_INC,   6'd2,  1'b1, '{16'sd1,  16'sd1,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_QUERY, 6'd3,  1'b1, '{16'sd0,  16'sd1,  7'd1,  1'b1}},
    '{1'b1, 7'd0,   REQ_INC,   6'd0,  1'b0, '0},
    '{1'b0, 7'd0,   REQ_QUERY, 6'd1,  1'b1, '{16'sd0,  -16'sd1, 7'd1,  1'b1}},
    '{1'b0, 7'd0,   REQ_INC,   6'd0,  1'b1, '{16'sd0,  16'sd0,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_DEC,   6'd0,  1'b1, '{-16'sd1, -16'sd1, 7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_DEC,   6'd63, 1'b1, '{16'sd0,  -16'sd1, 7'd1,  1'b1}},
    '{1'b1, 7'd127, REQ_INC,   6'd0,  1'b0, '0},
    '{1'b0, 7'd0,   REQ_QUERY, 6'd2,  1'b1, '{16'sd1,  16'sd1,  7'd1,  1'b0}},
    '{1'b0, 7'd0,   REQ_CLR,   6'd2,  1'b1, '{16'sd0,  16'sd0,  7'd63, 1'b0}},
    '{1'b0, 7'd0,   REQ_INC,   6'd63, 1'b0, '0},
    '{1'b0, 7'd0,   REQ_DEC,   6'd42, 1'b0, '0},
    '{1'b0, 7'd0,   REQ_CLR,   6'd0,  1'b0, '0},
    '{1'b1, 7'd64,  REQ_INC,   6'd0,  1'b0, '0},
    '{1'b0, 7'd0,   REQ_QUERY, 6'd63, 1'b0, '0},
    '{1'b0, 7'd0,   REQ_INC,   6'd31, 1'b0, '0},
    '{1'b0, 7'd0,   REQ_QUERY, 6'd0,  1'b0, '0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CfgWidth-1:0]          cfg_wdata;
  logic                         start;
  logic                         busy;
  req_e                         req_type;
  logic [IndexWidth-1:0]        counter_index;
  logic                         done;
  logic signed [ValueWidth-1:0] counter_value;
  logic signed [ValueWidth-1:0] max_value;
  logic [HoldersWidth-1:0]      max_holders;
  logic                         bad_index;

  // Shadow copy of the bank and its maximum tracking.
  logic signed [ValueWidth-1:0] bank [NumCountersDef];
  logic [CfgWidth-1:0]          count_reg;
  logic signed [ValueWidth-1:0] peak;
  int unsigned                  peak_holders;

  tally_t      pending_tallies [$];
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned bad_requests;
  int unsigned saturated;
  int unsigned settings_written;

  counter_bank_max_tracker_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .start_i         (start),
    .busy_o          (busy),
    .req_type_i      (req_type),
    .counter_index_i (counter_index),
    .done_o          (done),
    .counter_value_o (counter_value),
    .max_value_o     (max_value),
    .max_holders_o   (max_holders),
    .bad_index_o     (bad_index)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned counters_live();
    int unsigned n;
    n = 32'(count_reg);
    if (n < 1) n = 1;
    if (n > NumCountersDef) n = NumCountersDef;
    return n;
  endfunction

  function automatic void rescan_peak();
    int unsigned n;
    n = counters_live();
    peak = bank[0];
    peak_holders = 0;
    for (int k = 0; k < n; k++) if (bank[k] > peak) peak = bank[k];
    for (int k = 0; k < n; k++) if (bank[k] == peak) peak_holders++;
  endfunction

  function automatic tally_t apply_request(req_e req, logic [IndexWidth-1:0] index);
    tally_t t;
    logic signed [ValueWidth-1:0] c;
    t = '0;
    if (index >= counters_live()) begin
      t.bad = 1'b1;
      bad_requests++;
    end else begin
      c = bank[index];
      case (req)
        REQ_INC: begin
          if (c == CountTop) saturated++;
          else c = c + 16'sd1;
        end
        REQ_DEC: begin
          if (c == CountBottom) saturated++;
          else c = c - 16'sd1;
        end
        REQ_CLR: c = '0;
        default: ;
      endcase
      bank[index] = c;
      rescan_peak();
      t.value = c;
    end
    t.peak = peak;
    t.holders = HoldersWidth'(peak_holders);
    return t;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A word is taken at a rising edge with start high and busy low. Busy is read
  // right after the edge, before the block's flops have moved.
  task automatic send_word(input req_e req, input logic [IndexWidth-1:0] index,
                           input int unsigned gap, input logic typed, input tally_t want);
    tally_t got;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req_type <= req;
    counter_index <= index;
    do @(posedge clk); while (busy);
    got = apply_request(req, index);
    pending_tallies = {pending_tallies, (typed ? want : got)};
  endtask

  task automatic write_count(input logic [CfgWidth-1:0] value);
    @(negedge clk) start <= 1'b0;
    while (pending_tallies.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    count_reg = value;
    rescan_peak();
    settings_written++;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    tally_t want;
    if (rst_n && done) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result word: value %0d max %0d holders %0d bad %0b",
                 $time, counter_value, max_value, max_holders, bad_index);
        fail_count++;
      end else begin
        want = pending_tallies.pop_front();
        results_checked++;
        if (counter_value !== want.value) begin
          $display("%0t: counter_value expected %0d, got %0d", $time, want.value, counter_value);
          fail_count++;
        end
        if (max_value !== want.peak) begin
          $display("%0t: max_value expected %0d, got %0d", $time, want.peak, max_value);
          fail_count++;
        end
        if (max_holders !== want.holders) begin
          $display("%0t: max_holders expected %0d, got %0d", $time, want.holders, max_holders);
          fail_count++;
        end
        if (bad_index !== want.bad) begin
          $display("%0t: bad_index expected %0b, got %0b", $time, want.bad, bad_index);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timed out after %0d cycles, %0d results outstanding",
             CycleLimit, pending_tallies.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned          roll;
    int unsigned          live;
    logic                 burst;
    logic [CfgWidth-1:0]  setting;
    req_e                 req;
    logic [IndexWidth-1:0] index;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    req_type = REQ_INC;
    counter_index = '0;
    fail_count = 0;
    results_checked = 0;
    bad_requests = 0;
    saturated = 0;
    settings_written = 0;
    foreach (bank[k]) bank[k] = '0;
    count_reg = CfgResetValue;
    peak = '0;
    peak_holders = counters_live();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      if (Plan[r].is_cfg) write_count(Plan[r].count);
      else send_word(Plan[r].req, Plan[r].index, idle_gap(), Plan[r].typed, Plan[r].want);
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: setting = 7'd1;
        1: setting = 7'd64;
        2: setting = 7'd0;
        3: setting = 7'd127;
        4: setting = 7'd2;
        default: setting = CfgWidth'($urandom_range(0, 127));
      endcase
      write_count(setting);
      burst = ($urandom_range(0, 3) == 0);
      repeat (WordsPerPhase) begin
        live = counters_live();
        roll = $urandom_range(0, 99);
        req = (roll < 40) ? REQ_INC : (roll < 75) ? REQ_DEC : (roll < 85) ? REQ_CLR : REQ_QUERY;
        if ($urandom_range(0, 9) == 0) index = IndexWidth'($urandom_range(0, 63));
        else index = IndexWidth'($urandom_range(0, live - 1));
        send_word(req, index, burst ? 0 : idle_gap(), 1'b0, '0);
      end
    end

    @(negedge clk) start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d result words over %0d counter-count settings;", results_checked,
             settings_written);
    $display("%0d requests hit an unused index and %0d hit a saturation limit.",
             bad_requests, saturated);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
